FILE: design/tft_pkg.sv
// package for the tcp flow tracker: flow states, flags, status codes
// no dependencies
package tft_pkg;

  localparam logic [1:0] ST_SYN_SENT    = 2'd0;
  localparam logic [1:0] ST_SYN_RCVD    = 2'd1;
  localparam logic [1:0] ST_ESTABLISHED = 2'd2;
  localparam logic [1:0] ST_CLOSED      = 2'd3;

  localparam int FLAG_FIN_BIT = 0;
  localparam int FLAG_SYN_BIT = 1;
  localparam int FLAG_RST_BIT = 2;
  localparam int FLAG_ACK_BIT = 4;

  localparam logic [2:0] STAT_DROP_MISS = 3'd0;
  localparam logic [2:0] STAT_CREATED   = 3'd1;
  localparam logic [2:0] STAT_UPDATED   = 3'd2;
  localparam logic [2:0] STAT_DROP_FULL = 3'd3;
  localparam logic [2:0] STAT_SWEEP     = 3'd4;

  localparam logic [1:0] CFG_CLOSED   = 2'd0;
  localparam logic [1:0] CFG_SYN_SENT = 2'd1;
  localparam logic [1:0] CFG_SYN_RCVD = 2'd2;
  localparam logic [1:0] CFG_IDLE     = 2'd3;

  localparam logic [47:0] BYTES_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] PACKETS_MAX = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_W, S_UPD, S_LNK_RD, S_LNK_W, S_CREATE,
    S_EV_RD, S_EV_W, S_EV_CHK, S_OUT
  } seq_state_t;

endpackage

FILE: design/tcp_flow_tracker_lru.sv
// top level of the tcp flow tracker: sequencer, flow table memories, lru list
// depends on tft_pkg and tft_cmp
//
// Keeps up to FLOW_CAPACITY tcp flows keyed by the five-tuple in most recently
// used order. One item is taken at a time; in_tready is low while it runs. A
// packet walks the table one slot at a time through a single key comparator
// (registered memory read) until a hit or the last slot; a sweep evicts
// expired entries from the tail one at a time until one has not expired or
// the table is empty. The result sits in an output register until taken, and
// the next transfer is accepted only after the result has been taken. Valid
// bits are flip-flops cleared by reset; the key, counter and link memories
// are undefined until written.
module tcp_flow_tracker_lru
  import tft_pkg::*;
#(
  parameter int FLOW_CAPACITY = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // src_ip, dst_ip, src_port, dst_port, protocol, flag_byte,
  // payload_bytes, now_seconds
  input  logic [159:0] in_tdata,
  // cmd
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, flow_state, flow_bytes, flow_packets, flow_slot, evict_total,
  // active_flows (zero fill at top)
  output logic [111:0] out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);
  localparam int AW = (FLOW_CAPACITY > 1) ? $clog2(FLOW_CAPACITY) : 1;
  localparam int CW = $clog2(FLOW_CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(FLOW_CAPACITY);
  localparam logic [AW:0] LAST = (AW+1)'(FLOW_CAPACITY - 1);

  // memories
  logic [63:0] mem_a  [FLOW_CAPACITY];
  logic [39:0] mem_b  [FLOW_CAPACITY];
  logic [1:0]  mem_st [FLOW_CAPACITY];
  logic [47:0] mem_by [FLOW_CAPACITY];
  logic [31:0] mem_pk [FLOW_CAPACITY];
  logic [31:0] mem_ls [FLOW_CAPACITY];
  logic [AW-1:0] mem_old [FLOW_CAPACITY];
  logic [AW-1:0] mem_new [FLOW_CAPACITY];
  logic [FLOW_CAPACITY-1:0] valid_r;

  seq_state_t state_r, state_nxt;
  logic [15:0] to_r [4];
  logic [AW-1:0] head_r, tail_r;
  logic [CW-1:0] count_r;
  logic [63:0]   ka_r;
  logic [39:0]   kb_r;
  logic [7:0]    flags_r;
  logic [15:0]   pay_r;
  logic [31:0]   now_r;
  logic [AW:0]   scan_r;
  logic [AW-1:0] rd_addr_r, slot_r, free_r;
  logic          free_ok_r;
  logic [63:0]   rd_a_r;
  logic [39:0]   rd_b_r;
  logic          rd_v_r;
  logic [1:0]    rd_st_r;
  logic [47:0]   rd_by_r;
  logic [31:0]   rd_pk_r, rd_ls_r;
  logic [AW-1:0] rd_old_r, rd_new_r;
  logic [8:0]    evict_r;
  logic [2:0]    o_status_r;
  logic [1:0]    o_state_r;
  logic [47:0]   o_bytes_r;
  logic [31:0]   o_pk_r;
  logic [7:0]    o_slot_r;
  logic          out_valid_r;

  logic c_hit, c_free;
  tft_cmp u_cmp (
    .key_a(ka_r), .key_b(kb_r), .ent_a(rd_a_r), .ent_b(rd_b_r),
    .ent_valid(rd_v_r), .hit(c_hit), .free(c_free)
  );

  logic syn, ack, fin, rst;
  assign syn = flags_r[FLAG_SYN_BIT];
  assign ack = flags_r[FLAG_ACK_BIT];
  assign fin = flags_r[FLAG_FIN_BIT];
  assign rst = flags_r[FLAG_RST_BIT];

  // timeout check of the entry at the tail
  logic [15:0] tmo;
  logic [31:0] age;
  logic        expired;
  always_comb begin
    case (rd_st_r)
      ST_CLOSED:   tmo = to_r[CFG_CLOSED];
      ST_SYN_SENT: tmo = to_r[CFG_SYN_SENT];
      ST_SYN_RCVD: tmo = to_r[CFG_SYN_RCVD];
      default:     tmo = to_r[CFG_IDLE];
    endcase
    age = now_r - rd_ls_r;
    expired = age > {16'd0, tmo};
  end

  // updated counters and next flow state on a hit
  logic [47:0] new_by;
  logic [31:0] new_pk;
  logic [1:0]  new_st;
  always_comb begin
    new_by = (rd_by_r > BYTES_MAX - {32'd0, pay_r}) ? BYTES_MAX
             : rd_by_r + {32'd0, pay_r};
    new_pk = (rd_pk_r < PACKETS_MAX) ? rd_pk_r + 32'd1 : rd_pk_r;
    if (rd_st_r == ST_SYN_SENT && syn && ack) new_st = ST_SYN_RCVD;
    else if (rd_st_r == ST_SYN_RCVD && ack) new_st = ST_ESTABLISHED;
    else if (fin || rst) new_st = ST_CLOSED;
    else new_st = rd_st_r;
  end

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, 9'(count_r), evict_r, o_slot_r, o_pk_r, o_bytes_r,
                       o_state_r, o_status_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_tvalid && in_tready) state_nxt = in_tuser ? S_EV_RD : S_SCAN;
      S_SCAN:   state_nxt = S_SCAN_W;
      S_SCAN_W: begin
        if (c_hit) state_nxt = S_UPD;
        else if (scan_r == LAST) begin
          if (syn && !ack && count_r < CAP && (free_ok_r || c_free)) state_nxt = S_CREATE;
          else state_nxt = S_OUT;
        end else state_nxt = S_SCAN;
      end
      S_UPD:    state_nxt = (slot_r != head_r && count_r > 1) ? S_LNK_RD : S_OUT;
      S_LNK_RD: state_nxt = S_LNK_W;
      S_LNK_W:  state_nxt = S_OUT;
      S_CREATE: state_nxt = S_OUT;
      S_EV_RD:  state_nxt = (count_r == '0) ? S_OUT : S_EV_W;
      S_EV_W:   state_nxt = S_EV_CHK;
      S_EV_CHK: state_nxt = expired ? S_EV_RD : S_OUT;
      S_OUT:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      count_r <= '0;
      out_valid_r <= 1'b0;
      to_r[0] <= 16'd5; to_r[1] <= 16'd10; to_r[2] <= 16'd10; to_r[3] <= 16'd300;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) to_r[cfg_index] <= cfg_wdata;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_UPD: ;
        S_LNK_W: begin
          // unlink then push at head
          if (slot_r == tail_r) tail_r <= rd_new_r;
          head_r <= slot_r;
        end
        S_CREATE: begin
          valid_r[free_r] <= 1'b1;
          head_r <= free_r;
          if (count_r == '0) tail_r <= free_r;
          count_r <= count_r + 1'b1;
        end
        S_EV_CHK: if (expired) begin
          valid_r[tail_r] <= 1'b0;
          if (count_r > 1) tail_r <= rd_new_r;
          count_r <= count_r - 1'b1;
        end
        S_OUT: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath and memories
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (in_tvalid && in_tready) begin
        ka_r <= in_tdata[63:0] == 64'd0 ? 64'd0 : {in_tdata[31:0], in_tdata[63:32]};
        kb_r <= {in_tdata[79:64], in_tdata[95:80], in_tdata[103:96]};
        flags_r <= in_tdata[111:104];
        pay_r <= in_tdata[127:112];
        now_r <= in_tdata[159:128];
        scan_r <= '0;
        free_ok_r <= 1'b0;
        evict_r <= '0;
        rd_addr_r <= '0;
      end
      S_SCAN_W: begin
        if (c_hit) slot_r <= rd_addr_r;
        if (c_free && !free_ok_r) begin free_ok_r <= 1'b1; free_r <= rd_addr_r; end
        // address of the next slot, read during the following scan cycle
        rd_addr_r <= scan_r[AW-1:0] + 1'b1;
        scan_r <= scan_r + 1'b1;
      end
      S_UPD: begin
        mem_by[slot_r] <= new_by;
        mem_pk[slot_r] <= new_pk;
        mem_ls[slot_r] <= now_r;
        mem_st[slot_r] <= new_st;
        o_bytes_r <= new_by; o_pk_r <= new_pk; o_state_r <= new_st;
        o_slot_r <= 8'(slot_r);
        o_status_r <= STAT_UPDATED;
      end
      S_LNK_W: begin
        if (slot_r != tail_r) begin
          mem_old[rd_new_r] <= rd_old_r;
          mem_new[rd_old_r] <= rd_new_r;
        end
        mem_old[slot_r] <= head_r;
        mem_new[head_r] <= slot_r;
      end
      S_CREATE: begin
        mem_a[free_r] <= ka_r; mem_b[free_r] <= kb_r;
        mem_st[free_r] <= ST_SYN_SENT;
        mem_by[free_r] <= {32'd0, pay_r};
        mem_pk[free_r] <= 32'd1;
        mem_ls[free_r] <= now_r;
        if (count_r != '0) begin
          mem_old[free_r] <= head_r;
          mem_new[head_r] <= free_r;
        end
        o_status_r <= STAT_CREATED; o_state_r <= ST_SYN_SENT;
        o_bytes_r <= {32'd0, pay_r}; o_pk_r <= 32'd1; o_slot_r <= 8'(free_r);
      end
      S_EV_RD: rd_addr_r <= tail_r;
      S_EV_CHK: if (expired) evict_r <= evict_r + 9'd1;
      default: ;
    endcase
    if (state_r == S_SCAN_W && !c_hit && scan_r == LAST) begin
      o_status_r <= (syn && !ack) ? STAT_DROP_FULL : STAT_DROP_MISS;
      o_state_r <= '0; o_bytes_r <= '0; o_pk_r <= '0; o_slot_r <= '0;
    end
    if (state_r == S_EV_RD) begin
      o_status_r <= STAT_SWEEP;
      o_state_r <= '0; o_bytes_r <= '0; o_pk_r <= '0; o_slot_r <= '0;
    end
    if (state_r == S_UPD) rd_addr_r <= slot_r;
    // registered memory read
    rd_a_r <= mem_a[rd_addr_r]; rd_b_r <= mem_b[rd_addr_r];
    rd_v_r <= valid_r[rd_addr_r];
    rd_st_r <= mem_st[rd_addr_r]; rd_by_r <= mem_by[rd_addr_r];
    rd_pk_r <= mem_pk[rd_addr_r]; rd_ls_r <= mem_ls[rd_addr_r];
    rd_old_r <= mem_old[rd_addr_r]; rd_new_r <= mem_new[rd_addr_r];
  end

endmodule

FILE: design/tft_cmp.sv
// shared key compare and free-slot test for one table entry (combinational)
// depends on tft_pkg
module tft_cmp
  import tft_pkg::*;
(
  input  logic [63:0] key_a,
  input  logic [39:0] key_b,
  input  logic [63:0] ent_a,
  input  logic [39:0] ent_b,
  input  logic        ent_valid,
  output logic        hit,
  output logic        free
);
  // one entry: key match when valid, free when not valid
  assign hit  = ent_valid && (ent_a == key_a) && (ent_b == key_b);
  assign free = !ent_valid;
endmodule
